>>> rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants, codes and controller/datapath handshake types for the
// min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int CAPACITY_DEF      = 64;
	localparam int PRIORITY_BITS_DEF = 16;
	localparam int PAYLOAD_BITS_DEF  = 32;

	localparam int KIND_W   = 1;
	localparam int PRI_W    = 16;
	localparam int PAY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 7;

	localparam logic [KIND_W-1:0] KIND_PUSH = 1'b0;
	localparam logic [KIND_W-1:0] KIND_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                accept;
		logic                rd_parent;
		logic                move_up;
		logic                rd_root_last;
		logic                take_top;
		logic                rd_child;
		logic                move_down;
		logic                place;
		logic                cnt_inc;
		logic                cnt_dec;
		logic                load_out;
		logic [STATUS_W-1:0] res_status;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic at_root;
		logic up_move;
		logic has_child;
		logic down_move;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/mhpq_req_if.sv
// ----------------------------------------------------------------------------
// mhpq_req_if
// Request channel: push or pop word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhpq_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [mhpq_pkg::KIND_W-1:0]            kind;
	logic [mhpq_pkg::PRI_W-1:0]             priority_req;
	logic [mhpq_pkg::PAY_W-1:0]             payload;

	modport source (output valid, kind, priority_req, payload, input ready);
	modport sink (input valid, kind, priority_req, payload, output ready);
endinterface

>>> rtl/mhpq_rsp_if.sv
// ----------------------------------------------------------------------------
// mhpq_rsp_if
// Response channel: one result word per request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhpq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [mhpq_pkg::STATUS_W-1:0]     status;
	logic [mhpq_pkg::PAY_W-1:0]        popped_payload;
	logic [mhpq_pkg::PRI_W-1:0]        popped_priority;
	logic [mhpq_pkg::OCC_W-1:0]        occupancy;
	logic                              is_empty;

	modport source (output valid, status, popped_payload, popped_priority, occupancy,
		is_empty, input ready);
	modport sink (input valid, status, popped_payload, popped_priority, occupancy,
		is_empty, output ready);
endinterface

>>> rtl/min_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core
// Bounded binary min-heap priority queue with one request and one response
// channel.
//
// A req word carries kind (push or pop), priority_req and payload. Push
// inserts the entry and sifts it up; pop removes the smallest-priority entry
// (ties resolve by heap order) and sifts the last entry down. Every req word
// yields exactly one rsp word carrying status, the popped entry (zero unless a
// good pop), occupancy and is_empty.
// Pop on an empty heap reports empty; push on a full heap is dropped.
// One request is processed at a time. Each sift level is one registered memory
// read followed by one compare and write.
// The rsp word sits in an output register: req.ready returns high once the
// word is loaded, even while rsp.ready is low; a second finished word waits
// in the sequencer until the register frees.
// Reset empties the heap at once; storage contents are not cleared.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_core #(
	parameter int CAPACITY      = mhpq_pkg::CAPACITY_DEF,
	parameter int PRIORITY_BITS = mhpq_pkg::PRIORITY_BITS_DEF,
	parameter int PAYLOAD_BITS  = mhpq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mhpq_req_if.sink    req,
	mhpq_rsp_if.source  rsp
);
	import mhpq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_kind  (req.kind),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mhpq_dp #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIORITY_BITS),
		.PAYLOAD_BITS  (PAYLOAD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_priority   (req.priority_req),
		.in_payload    (req.payload),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.out_status    (rsp.status),
		.out_payload   (rsp.popped_payload),
		.out_priority  (rsp.popped_priority),
		.out_occupancy (rsp.occupancy),
		.out_empty     (rsp.is_empty)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while previous one still in work");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |->
		(rsp.popped_payload == '0 && rsp.popped_priority == '0))
		else $error("error response carries popped data");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_EMPTY) |-> rsp.is_empty)
		else $error("empty pop reported with nonempty heap");

	a_no_mem_op_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.place || cmd.move_up || cmd.move_down) |-> !req.ready)
		else $error("heap write while sequencer idle");

endmodule

>>> rtl/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for push sift-up and pop sift-down; drives datapath commands.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [mhpq_pkg::KIND_W-1:0]   in_kind,
	output logic                          in_ready,
	input  mhpq_pkg::sts_t                sts,
	output mhpq_pkg::cmd_t                cmd
);
	import mhpq_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_PUSH_CHK = 3'd1;
	localparam logic [2:0] S_PUSH_CMP = 3'd2;
	localparam logic [2:0] S_POP_RD0  = 3'd3;
	localparam logic [2:0] S_POP_TAKE = 3'd4;
	localparam logic [2:0] S_POP_RDC  = 3'd5;
	localparam logic [2:0] S_POP_CMP  = 3'd6;
	localparam logic [2:0] S_FINISH   = 3'd7;

	logic [2:0]          state_q, state_d;
	logic [STATUS_W-1:0] res_q, res_d;
	logic                accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d        = state_q;
		res_d          = res_q;
		cmd            = '0;
		cmd.res_status = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.accept = 1'b1;
					if (in_kind == KIND_PUSH) begin
						if (sts.cnt_full) begin
							res_d   = ST_FULL;
							state_d = S_FINISH;
						end else begin
							res_d   = ST_OK;
							state_d = S_PUSH_CHK;
						end
					end else begin
						if (sts.cnt_zero) begin
							res_d   = ST_EMPTY;
							state_d = S_FINISH;
						end else begin
							res_d   = ST_OK;
							state_d = S_POP_RD0;
						end
					end
				end
			end
			S_PUSH_CHK: begin
				if (sts.at_root) begin
					cmd.place   = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d     = S_FINISH;
				end else begin
					cmd.rd_parent = 1'b1;
					state_d       = S_PUSH_CMP;
				end
			end
			S_PUSH_CMP: begin
				if (sts.up_move) begin
					cmd.move_up = 1'b1;
					state_d     = S_PUSH_CHK;
				end else begin
					cmd.place   = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_POP_RD0: begin
				cmd.rd_root_last = 1'b1;
				state_d          = S_POP_TAKE;
			end
			S_POP_TAKE: begin
				cmd.take_top = 1'b1;
				state_d      = S_POP_RDC;
			end
			S_POP_RDC: begin
				if (sts.has_child) begin
					cmd.rd_child = 1'b1;
					state_d      = S_POP_CMP;
				end else begin
					cmd.place   = 1'b1;
					cmd.cnt_dec = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_POP_CMP: begin
				if (sts.down_move) begin
					cmd.move_down = 1'b1;
					state_d       = S_POP_RDC;
				end else begin
					cmd.place   = 1'b1;
					cmd.cnt_dec = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

>>> rtl/mhpq_dp.sv
// ----------------------------------------------------------------------------
// mhpq_dp
// Heap storage, entry count, moving-entry and position registers, compare
// logic and the result word register.
// ----------------------------------------------------------------------------
module mhpq_dp #(
	parameter int CAPACITY      = mhpq_pkg::CAPACITY_DEF,
	parameter int PRIORITY_BITS = mhpq_pkg::PRIORITY_BITS_DEF,
	parameter int PAYLOAD_BITS  = mhpq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [mhpq_pkg::PRI_W-1:0]      in_priority,
	input  logic [mhpq_pkg::PAY_W-1:0]      in_payload,
	input  mhpq_pkg::cmd_t                  cmd,
	output mhpq_pkg::sts_t                  sts,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [mhpq_pkg::STATUS_W-1:0]   out_status,
	output logic [mhpq_pkg::PAY_W-1:0]      out_payload,
	output logic [mhpq_pkg::PRI_W-1:0]      out_priority,
	output logic [mhpq_pkg::OCC_W-1:0]      out_occupancy,
	output logic                            out_empty
);
	import mhpq_pkg::*;

	localparam int ADDR_W  = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int POS_W   = CNT_W + 1;
	localparam int ENTRY_W = PRIORITY_BITS + PAYLOAD_BITS;

	logic [ENTRY_W-1:0]       mem [CAPACITY];
	logic [ENTRY_W-1:0]       rd_a_q, rd_b_q;
	logic [CNT_W-1:0]         count_q;
	logic [POS_W-1:0]         at_q;
	logic [PRIORITY_BITS-1:0] key_pri_q, top_pri_q;
	logic [PAYLOAD_BITS-1:0]  key_pay_q, top_pay_q;
	logic                     out_valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic [PAY_W-1:0]         out_pay_q;
	logic [PRI_W-1:0]         out_pri_q;
	logic [OCC_W-1:0]         occ_q;
	logic                     empty_q;

	logic [POS_W-1:0]         count_pos, left, right, parent, child;
	logic [PRIORITY_BITS-1:0] a_pri, b_pri, child_pri;
	logic                     sel_right;
	logic [ENTRY_W-1:0]       child_entry, wr_data;
	logic [ADDR_W-1:0]        rd_addr_a, rd_addr_b, wr_addr;
	logic                     wr_en;

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [POS_W-1:0] slot);
		logic [POS_W-1:0] idx;
		idx = slot - POS_W'(1);
		return idx[ADDR_W-1:0];
	endfunction

	assign count_pos = POS_W'(count_q);
	assign left      = {at_q[POS_W-2:0], 1'b0};
	assign right     = {at_q[POS_W-2:0], 1'b1};
	assign parent    = at_q >> 1;

	assign a_pri     = rd_a_q[ENTRY_W-1:PAYLOAD_BITS];
	assign b_pri     = rd_b_q[ENTRY_W-1:PAYLOAD_BITS];
	assign sel_right = (left != count_pos) && (a_pri > b_pri);
	assign child     = sel_right ? right : left;
	assign child_entry = sel_right ? rd_b_q : rd_a_q;
	assign child_pri = child_entry[ENTRY_W-1:PAYLOAD_BITS];

	assign sts.cnt_zero  = (count_q == '0);
	assign sts.cnt_full  = (count_q == CNT_W'(CAPACITY));
	assign sts.at_root   = (at_q == POS_W'(1));
	assign sts.up_move   = (key_pri_q < a_pri);
	assign sts.has_child = (left <= count_pos);
	assign sts.down_move = (key_pri_q > child_pri);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		rd_addr_a = slot_addr(left);
		rd_addr_b = slot_addr(right);
		if (cmd.rd_parent) begin
			rd_addr_a = slot_addr(parent);
		end else if (cmd.rd_root_last) begin
			rd_addr_a = slot_addr(POS_W'(1));
			rd_addr_b = slot_addr(count_pos);
		end
	end

	always_comb begin
		wr_en   = cmd.move_up || cmd.move_down || cmd.place;
		wr_addr = slot_addr(at_q);
		wr_data = {key_pri_q, key_pay_q};
		if (cmd.move_up) begin
			wr_data = rd_a_q;
		end else if (cmd.move_down) begin
			wr_data = child_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_parent || cmd.rd_child || cmd.rd_root_last) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_pri_q <= PRIORITY_BITS'(32'(in_priority));
			key_pay_q <= PAYLOAD_BITS'(32'(in_payload));
			top_pri_q <= '0;
			top_pay_q <= '0;
			at_q      <= count_pos + POS_W'(1);
		end else if (cmd.take_top) begin
			top_pri_q <= rd_a_q[ENTRY_W-1:PAYLOAD_BITS];
			top_pay_q <= rd_a_q[PAYLOAD_BITS-1:0];
			key_pri_q <= b_pri;
			key_pay_q <= rd_b_q[PAYLOAD_BITS-1:0];
			at_q      <= POS_W'(1);
		end else if (cmd.move_up) begin
			at_q <= parent;
		end else if (cmd.move_down) begin
			at_q <= child;
		end
		if (cmd.load_out) begin
			status_q  <= cmd.res_status;
			out_pay_q <= PAY_W'(top_pay_q);
			out_pri_q <= PRI_W'(top_pri_q);
			occ_q     <= OCC_W'(count_q);
			empty_q   <= (count_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_status    = status_q;
	assign out_payload   = out_pay_q;
	assign out_priority  = out_pri_q;
	assign out_occupancy = occ_q;
	assign out_empty     = empty_q;

endmodule

>>> tb/min_heap_priority_queue_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core_tb
// Self-checking bench for the min-heap priority queue. An opening table covers
// reset, extreme values, empty pops and priority ties. Random push/pop runs
// follow, including fill-to-overflow and drain-to-underflow runs. Every rsp
// word is compared with a local heap model. Both channels idle at random, the
// sink holds off once for a long stretch, and the source pauses once until
// every pending word has drained.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_core_tb;
	import mhpq_pkg::*;

	localparam int HEAP_DEPTH   = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 950;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_TAIL   = 40;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAY_W-1:0]    popped_payload;
		logic [PRI_W-1:0]    popped_priority;
		logic [OCC_W-1:0]    occupancy;
		logic                is_empty;
	} heap_rsp_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PRI_W-1:0]  pri;
		logic [PAY_W-1:0]  pay;
		logic              typed;
		heap_rsp_t         want;
	} plan_row_t;

	localparam heap_rsp_t NO_WANT = '0;

	localparam plan_row_t OPENING_PLAN [0:20] = '{
		'{KIND_POP,  16'h0000, 32'h00000000, 1'b1, '{ST_EMPTY, 32'h0, 16'h0, 7'd0, 1'b1}},
		'{KIND_PUSH, 16'hFFFF, 32'hFFFFFFFF, 1'b1, '{ST_OK, 32'h0, 16'h0, 7'd1, 1'b0}},
		'{KIND_POP,  16'hFFFF, 32'hFFFFFFFF, 1'b1,
			'{ST_OK, 32'hFFFFFFFF, 16'hFFFF, 7'd0, 1'b1}},
		'{KIND_POP,  16'h0000, 32'h00000000, 1'b1, '{ST_EMPTY, 32'h0, 16'h0, 7'd0, 1'b1}},
		'{KIND_PUSH, 16'h0000, 32'h00000000, 1'b1, '{ST_OK, 32'h0, 16'h0, 7'd1, 1'b0}},
		'{KIND_PUSH, 16'hFFFF, 32'h12345678, 1'b1, '{ST_OK, 32'h0, 16'h0, 7'd2, 1'b0}},
		'{KIND_POP,  16'h0000, 32'h00000000, 1'b1, '{ST_OK, 32'h0, 16'h0, 7'd1, 1'b0}},
		'{KIND_PUSH, 16'h1000, 32'hAAAA5555, 1'b0, NO_WANT},
		'{KIND_PUSH, 16'h1000, 32'h5555AAAA, 1'b0, NO_WANT},
		'{KIND_PUSH, 16'h0800, 32'h0F0F0F0F, 1'b0, NO_WANT},
		'{KIND_PUSH, 16'h2000, 32'hF0F0F0F0, 1'b0, NO_WANT},
		'{KIND_PUSH, 16'h1000, 32'h00FF00FF, 1'b0, NO_WANT},
		'{KIND_PUSH, 16'h0001, 32'h80000001, 1'b0, NO_WANT},
		'{KIND_POP,  16'h0000, 32'h00000000, 1'b0, NO_WANT},
		'{KIND_POP,  16'h0000, 32'h00000000, 1'b0, NO_WANT},
		'{KIND_POP,  16'h0000, 32'h00000000, 1'b0, NO_WANT},
		'{KIND_POP,  16'h0000, 32'h00000000, 1'b0, NO_WANT},
		'{KIND_POP,  16'h0000, 32'h00000000, 1'b0, NO_WANT},
		'{KIND_POP,  16'h0000, 32'h00000000, 1'b0, NO_WANT},
		'{KIND_POP,  16'h0000, 32'h00000000, 1'b0, NO_WANT},
		'{KIND_POP,  16'h0000, 32'h00000000, 1'b1, '{ST_EMPTY, 32'h0, 16'h0, 7'd0, 1'b1}}
	};

	logic clk;
	logic arst_n;

	mhpq_req_if req_ch ();
	mhpq_rsp_if rsp_ch ();

	min_heap_priority_queue_core i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	logic [PRI_W-1:0] kept_pri [1:HEAP_DEPTH];
	logic [PAY_W-1:0] kept_pay [1:HEAP_DEPTH];
	int unsigned      kept_count;

	heap_rsp_t pending_rsp_q [$];
	int unsigned fail_count;
	int unsigned cycle_count;
	bit          req_quiet;
	bit          rsp_quiet;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic heap_rsp_t heap_apply(input logic [KIND_W-1:0] kind,
		input logic [PRI_W-1:0] pri, input logic [PAY_W-1:0] pay);
		heap_rsp_t        r;
		int unsigned      at;
		int unsigned      up;
		int unsigned      kid;
		bit               done;
		logic [PRI_W-1:0] mv_pri;
		logic [PAY_W-1:0] mv_pay;
		r = '0;
		r.status = ST_OK;
		if (kind == KIND_PUSH) begin
			if (kept_count >= HEAP_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				at = kept_count + 1;
				done = 1'b0;
				while (at != 1 && !done) begin
					up = at / 2;
					if (pri < kept_pri[up]) begin
						kept_pri[at] = kept_pri[up];
						kept_pay[at] = kept_pay[up];
						at = up;
					end else begin
						done = 1'b1;
					end
				end
				kept_pri[at] = pri;
				kept_pay[at] = pay;
				kept_count++;
			end
		end else if (kept_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.popped_priority = kept_pri[1];
			r.popped_payload  = kept_pay[1];
			mv_pri = kept_pri[kept_count];
			mv_pay = kept_pay[kept_count];
			at = 1;
			done = 1'b0;
			while (!done) begin
				kid = at * 2;
				if (kid > kept_count) begin
					done = 1'b1;
				end else begin
					if (kid < kept_count && kept_pri[kid] > kept_pri[kid + 1])
						kid++;
					if (mv_pri <= kept_pri[kid]) begin
						done = 1'b1;
					end else begin
						kept_pri[at] = kept_pri[kid];
						kept_pay[at] = kept_pay[kid];
						at = kid;
					end
				end
			end
			kept_pri[at] = mv_pri;
			kept_pay[at] = mv_pay;
			kept_count--;
		end
		r.occupancy = kept_count[OCC_W-1:0];
		r.is_empty  = (kept_count == 0);
		return r;
	endfunction

	function automatic logic [PRI_W-1:0] draw_priority();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return PRI_W'($urandom_range(0, 7));
			default: return PRI_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic offer_word(input logic [KIND_W-1:0] kind, input logic [PRI_W-1:0] pri,
		input logic [PAY_W-1:0] pay, input logic typed, input heap_rsp_t want);
		int        gap;
		heap_rsp_t guess;
		gap = req_quiet ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.kind         <= kind;
		req_ch.priority_req <= pri;
		req_ch.payload      <= pay;
		req_ch.valid        <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		guess = heap_apply(kind, pri, pay);
		pending_rsp_q.push_back(typed ? want : guess);
	endtask

	// sink side: random stalls, one long hold-off
	initial begin
		int          stall;
		int unsigned rsp_taken;
		bit          long_hold_done;
		rsp_taken = 0;
		long_hold_done = 1'b0;
		rsp_quiet = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!long_hold_done && rsp_taken >= 250) begin
				long_hold_done = 1'b1;
				stall = LONG_HOLD;
			end else begin
				stall = rsp_quiet ? 0 : $urandom_range(0, 8);
			end
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			rsp_taken++;
			if ($urandom_range(0, 39) == 0)
				rsp_quiet = !rsp_quiet;
		end
	end

	always @(posedge clk) begin
		heap_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp_q.size() == 0) begin
				$error("rsp word with nothing pending");
				fail_count++;
			end else begin
				want = pending_rsp_q.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.popped_payload !== want.popped_payload) begin
					$error("popped_payload: expected %h, got %h", want.popped_payload,
						rsp_ch.popped_payload);
					fail_count++;
				end
				if (rsp_ch.popped_priority !== want.popped_priority) begin
					$error("popped_priority: expected %h, got %h", want.popped_priority,
						rsp_ch.popped_priority);
					fail_count++;
				end
				if (rsp_ch.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy,
						rsp_ch.occupancy);
					fail_count++;
				end
				if (rsp_ch.is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d", want.is_empty, rsp_ch.is_empty);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned      random_sent;
		int               run_len;
		int               mode;
		int               push_odds;
		bit               paused;
		logic [KIND_W-1:0] kind;
		random_sent = 0;
		paused = 1'b0;
		kept_count = 0;
		req_quiet = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_PUSH;
		req_ch.priority_req = '0;
		req_ch.payload = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(OPENING_PLAN); i++)
			offer_word(OPENING_PLAN[i].kind, OPENING_PLAN[i].pri, OPENING_PLAN[i].pay,
				OPENING_PLAN[i].typed, OPENING_PLAN[i].want);

		while (random_sent < RANDOM_ITEMS) begin
			req_quiet = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 9);
			if (mode == 8) begin
				// fill up, then overflow
				run_len = HEAP_DEPTH - kept_count + $urandom_range(1, 4);
				push_odds = 100;
			end else if (mode == 9) begin
				// drain, then underflow
				run_len = kept_count + $urandom_range(1, 3);
				push_odds = 0;
			end else begin
				run_len = $urandom_range(20, 40);
				push_odds = (mode < 4) ? 50 : (mode < 6) ? 80 : 20;
			end
			for (int n = 0; n < run_len; n++) begin
				kind = ($urandom_range(1, 100) <= push_odds) ? KIND_PUSH : KIND_POP;
				offer_word(kind, draw_priority(), $urandom, 1'b0, NO_WANT);
				random_sent++;
			end
			if (!paused && random_sent >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				req_ch.valid <= 1'b0;
				while (pending_rsp_q.size() != 0) @(posedge clk);
			end
		end
		req_ch.valid <= 1'b0;

		while (pending_rsp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
